// ===== rtl/first_fit_heap_allocator_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit heap allocator
// Checkers include this file and expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define FFHA_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffha assertion failed");

// next-cycle implication
`define FFHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffha assertion failed");

`endif

// ===== rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types, codes and helpers of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int FIELD_W   = 20;
  localparam int TYPE_W    = 2;
  localparam int STAT_W    = 2;
  localparam int HREG_W    = 7;
  localparam int HDR_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int SIZE_GRAIN = 16;

  localparam logic [FIELD_W-1:0] HEAP_RESET = 20'd65536;
  localparam logic [HREG_W-1:0]  HDR_RESET  = 7'd16;
  localparam logic [HDR_W-1:0]   HDR_DFLT   = 8'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR  = 1'b1;

  typedef enum logic [TYPE_W-1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_RESIZE = 2'd2,
    REQ_REINIT = 2'd3
  } req_e_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_UNKNOWN  = 2'd2
  } status_e_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_WCHK, S_SPLIT, S_SPLIT_WN, S_SPLIT_NX, S_SPLIT_END,
    S_GROW_OLD, S_REL, S_REL_PCHK, S_REL_NEXT, S_REL_NCHK, S_MERGE, S_PFIX,
    S_FIN_W, S_OUT
  } fsm_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  req_type;
    logic [FIELD_W-1:0] req_bytes;
    logic [FIELD_W-1:0] handle;
  } req_t;

  typedef struct packed {
    status_e_t          status;
    logic [FIELD_W-1:0] data_offset;
    logic [FIELD_W-1:0] granted_bytes;
  } rsp_t;

  function automatic logic [FIELD_W:0] round_up16(input logic [FIELD_W-1:0] v);
    logic [FIELD_W:0] s;
    s = {1'b0, v} + (FIELD_W+1)'(SIZE_GRAIN - 1);
    return s & ~((FIELD_W+1)'(SIZE_GRAIN - 1));
  endfunction

  function automatic logic [HDR_W-1:0] hdr_round(input logic [HREG_W-1:0] v);
    logic [HDR_W-1:0] s;
    s = ({1'b0, v} + HDR_W'(SIZE_GRAIN - 1)) & ~HDR_W'(SIZE_GRAIN - 1);
    return (s == '0) ? HDR_DFLT : s;
  endfunction

endpackage

// ===== rtl/ffha_if.sv =====
// ----------------------------------------------------------------------------
// ffha_if
// Valid/ready channels of the heap allocator: request, response, config.
// ----------------------------------------------------------------------------
interface ffha_req_if;
  logic                          valid;
  logic                          ready;
  logic [ffha_pkg::TYPE_W-1:0]   req_type;
  logic [ffha_pkg::FIELD_W-1:0]  req_bytes;
  logic [ffha_pkg::FIELD_W-1:0]  handle;
  modport source (output valid, req_type, req_bytes, handle, input ready);
  modport sink   (input valid, req_type, req_bytes, handle, output ready);
  modport mon    (input valid, ready, req_type, req_bytes, handle);
endinterface

interface ffha_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ffha_pkg::STAT_W-1:0]   status;
  logic [ffha_pkg::FIELD_W-1:0]  data_offset;
  logic [ffha_pkg::FIELD_W-1:0]  granted_bytes;
  modport source (output valid, status, data_offset, granted_bytes, input ready);
  modport sink   (input valid, status, data_offset, granted_bytes, output ready);
  modport mon    (input valid, ready, status, data_offset, granted_bytes);
endinterface

interface ffha_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ffha_pkg::CFG_IDX_W-1:0] index;
  logic [ffha_pkg::FIELD_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ffha_ram.sv =====
// ----------------------------------------------------------------------------
// ffha_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ffha_slots.sv =====
// ----------------------------------------------------------------------------
// ffha_slots
// Live-slot bitmap of the segment table and lowest free slot finder.
// ----------------------------------------------------------------------------
module ffha_slots #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            clear_all,
  input  logic                            set_en,
  input  logic [$clog2(MAX_SEGMENTS)-1:0] set_idx,
  input  logic                            clr_en,
  input  logic [$clog2(MAX_SEGMENTS)-1:0] clr_idx,
  output logic                            free_ok,
  output logic [$clog2(MAX_SEGMENTS)-1:0] free_idx
);

  localparam int IW = $clog2(MAX_SEGMENTS);

  logic [MAX_SEGMENTS-1:0] live_r, live_nxt;

  always_comb begin
    live_nxt = live_r;
    if (clear_all) begin
      live_nxt = MAX_SEGMENTS'(1);
    end else begin
      if (set_en) live_nxt[set_idx] = 1'b1;
      if (clr_en) live_nxt[clr_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= MAX_SEGMENTS'(1);
    end else begin
      live_r <= live_nxt;
    end
  end

  // slot zero always holds the list head and is never handed out
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = MAX_SEGMENTS - 1; i > 0; i--) begin
      if (!live_r[i]) begin
        free_ok  = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

endmodule

// ===== rtl/ffha_seq.sv =====
// ----------------------------------------------------------------------------
// ffha_seq
// Request sequencer: walks, splits and merges segments held in the table RAM.
// ----------------------------------------------------------------------------
module ffha_seq #(
  parameter int MAX_SEGMENTS   = 64,
  parameter int HEAP_ADDR_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  ffha_pkg::req_t                req,
  input  logic [ffha_pkg::FIELD_W-1:0]  heap_bytes,
  input  logic [ffha_pkg::HREG_W-1:0]   header_bytes,
  output logic                          cfg_ok,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output ffha_pkg::rsp_t                rsp
);

  localparam int A  = HEAP_ADDR_BITS;
  localparam int FW = ffha_pkg::FIELD_W;
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int LW = $clog2(MAX_SEGMENTS + 1);
  localparam int CW = ((A > FW) ? A : FW) + 2;
  localparam logic [LW-1:0] NONE = LW'(MAX_SEGMENTS);

  typedef struct packed {
    logic [A-1:0]  start;
    logic [A-1:0]  size;
    logic          used;
    logic [LW-1:0] next;
    logic [LW-1:0] prev;
  } ent_t;

  localparam int EW = $bits(ent_t);

  ffha_pkg::fsm_t   state_r, state_nxt, ret_r, ret_nxt;
  ffha_pkg::req_e_t type_r, type_nxt;
  logic             silent_r, silent_nxt;
  logic             alloc_r, alloc_nxt;
  logic             grow_r, grow_nxt;
  logic             shrink_r, shrink_nxt;
  logic [FW:0]      need_r, need_nxt;
  logic [FW-1:0]    handle_r, handle_nxt;
  logic [ffha_pkg::HDR_W-1:0] hdr_r, hdr_nxt;
  logic [IW-1:0]    ws_r, ws_nxt, c_r, c_nxt, xs_r, xs_nxt, ns_r, ns_nxt, os_r, os_nxt;
  logic [IW-1:0]    steps_r, steps_nxt;
  ent_t             cur_r, cur_nxt, xent_r, xent_nxt, nent_r, nent_nxt;
  ffha_pkg::rsp_t   res_r, res_nxt;

  logic             we;
  logic [IW-1:0]    wa, ra;
  ent_t             wd;
  logic [EW-1:0]    rd_raw;
  ent_t             e;

  logic             clear_all, set_en, clr_en, free_ok;
  logic [IW-1:0]    free_idx;

  logic [CW-1:0]    need_x, hdr_x, e_off, cur_off, cur_size_x, rem, heap_x, hdr_new_x;
  logic             e_hit, split_ok;
  logic [ffha_pkg::HDR_W-1:0] hdr_new;

  ffha_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_tab (
    .clk   (clk),
    .we    (we),
    .waddr (wa),
    .wdata (EW'(wd)),
    .raddr (ra),
    .rdata (rd_raw)
  );

  ffha_slots #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_slots (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear_all (clear_all),
    .set_en    (set_en),
    .set_idx   (free_idx),
    .clr_en    (clr_en),
    .clr_idx   (xs_r),
    .free_ok   (free_ok),
    .free_idx  (free_idx)
  );

  assign e          = ent_t'(rd_raw);
  assign need_x     = CW'(need_r);
  assign hdr_x      = CW'(hdr_r);
  assign e_off      = CW'(e.start) + hdr_x;
  assign cur_off    = CW'(cur_r.start) + hdr_x;
  assign cur_size_x = CW'(cur_r.size);
  assign rem        = cur_size_x - need_x;
  assign split_ok   = (rem >= hdr_x + CW'(ffha_pkg::SIZE_GRAIN)) && free_ok;
  assign hdr_new    = ffha_pkg::hdr_round(header_bytes);
  assign hdr_new_x  = CW'(hdr_new);
  assign heap_x     = CW'(heap_bytes);
  assign e_hit      = alloc_r ? (!e.used && CW'(e.size) >= need_x)
                              : (e.used && e_off[FW-1:0] == handle_r);

  assign req_ready = (state_r == ffha_pkg::S_IDLE);
  assign rsp_valid = (state_r == ffha_pkg::S_OUT);
  assign rsp       = res_r;
  assign cfg_ok    = (state_r != ffha_pkg::S_INIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ffha_pkg::S_INIT;
      ret_r    <= ffha_pkg::S_OUT;
      silent_r <= 1'b1;
      hdr_r    <= ffha_pkg::HDR_DFLT;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      silent_r <= silent_nxt;
      hdr_r    <= hdr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r   <= type_nxt;
    alloc_r  <= alloc_nxt;
    grow_r   <= grow_nxt;
    shrink_r <= shrink_nxt;
    need_r   <= need_nxt;
    handle_r <= handle_nxt;
    ws_r     <= ws_nxt;
    c_r      <= c_nxt;
    xs_r     <= xs_nxt;
    ns_r     <= ns_nxt;
    os_r     <= os_nxt;
    steps_r  <= steps_nxt;
    cur_r    <= cur_nxt;
    xent_r   <= xent_nxt;
    nent_r   <= nent_nxt;
    res_r    <= res_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    silent_nxt = silent_r;
    hdr_nxt    = hdr_r;
    type_nxt   = type_r;
    alloc_nxt  = alloc_r;
    grow_nxt   = grow_r;
    shrink_nxt = shrink_r;
    need_nxt   = need_r;
    handle_nxt = handle_r;
    ws_nxt     = ws_r;
    c_nxt      = c_r;
    xs_nxt     = xs_r;
    ns_nxt     = ns_r;
    os_nxt     = os_r;
    steps_nxt  = steps_r;
    cur_nxt    = cur_r;
    xent_nxt   = xent_r;
    nent_nxt   = nent_r;
    res_nxt    = res_r;
    we         = 1'b0;
    wa         = c_r;
    wd         = cur_r;
    ra         = ws_r;
    clear_all  = 1'b0;
    set_en     = 1'b0;
    clr_en     = 1'b0;

    unique case (state_r)
      ffha_pkg::S_INIT: begin
        we         = 1'b1;
        wa         = '0;
        wd.start   = '0;
        wd.size    = (heap_x >= hdr_new_x) ? A'(heap_x - hdr_new_x) : '0;
        wd.used    = 1'b0;
        wd.next    = NONE;
        wd.prev    = NONE;
        clear_all  = 1'b1;
        hdr_nxt    = hdr_new;
        silent_nxt = 1'b0;
        res_nxt    = '{ffha_pkg::ST_OK, '0, '0};
        state_nxt  = silent_r ? ffha_pkg::S_IDLE : ffha_pkg::S_OUT;
      end

      ffha_pkg::S_IDLE: begin
        ra = '0;
        if (req_valid) begin
          type_nxt   = ffha_pkg::req_e_t'(req.req_type);
          need_nxt   = ffha_pkg::round_up16(req.req_bytes);
          handle_nxt = req.handle;
          alloc_nxt  = (ffha_pkg::req_e_t'(req.req_type) == ffha_pkg::REQ_ALLOC);
          grow_nxt   = 1'b0;
          ws_nxt     = '0;
          steps_nxt  = '0;
          state_nxt  = (ffha_pkg::req_e_t'(req.req_type) == ffha_pkg::REQ_REINIT)
                       ? ffha_pkg::S_INIT : ffha_pkg::S_WCHK;
        end
      end

      // one list entry checked per cycle; next read issued as this one is judged
      ffha_pkg::S_WCHK: begin
        if (e_hit) begin
          c_nxt   = ws_r;
          cur_nxt = e;
          if (alloc_r) begin
            cur_nxt.used = 1'b1;
            shrink_nxt   = 1'b0;
            state_nxt    = ffha_pkg::S_SPLIT;
          end else if (type_r == ffha_pkg::REQ_FREE) begin
            res_nxt      = '{ffha_pkg::ST_OK, handle_r, '0};
            cur_nxt.used = 1'b0;
            state_nxt    = ffha_pkg::S_REL;
          end else if (CW'(e.size) > need_x) begin
            shrink_nxt = 1'b1;
            state_nxt  = ffha_pkg::S_SPLIT;
          end else if (CW'(e.size) < need_x) begin
            // grow: kept segment is the answer unless the new alloc succeeds
            os_nxt    = ws_r;
            res_nxt   = '{ffha_pkg::ST_NO_SPACE, handle_r, FW'(CW'(e.size))};
            alloc_nxt = 1'b1;
            grow_nxt  = 1'b1;
            ra        = '0;
            ws_nxt    = '0;
            steps_nxt = '0;
          end else begin
            res_nxt   = '{ffha_pkg::ST_OK, handle_r, FW'(CW'(e.size))};
            state_nxt = ffha_pkg::S_OUT;
          end
        end else if (e.next == NONE || steps_r == IW'(MAX_SEGMENTS - 1)) begin
          if (!grow_r) begin
            res_nxt = alloc_r ? '{ffha_pkg::ST_NO_SPACE, '0, '0}
                              : '{ffha_pkg::ST_UNKNOWN, '0, '0};
          end
          state_nxt = ffha_pkg::S_OUT;
        end else begin
          ra        = e.next[IW-1:0];
          ws_nxt    = e.next[IW-1:0];
          steps_nxt = steps_r + IW'(1);
        end
      end

      ffha_pkg::S_SPLIT: begin
        we = 1'b1;
        if (split_ok) begin
          set_en         = 1'b1;
          ns_nxt         = free_idx;
          nent_nxt.start = A'(cur_off + need_x);
          nent_nxt.size  = A'(rem - hdr_x);
          nent_nxt.used  = 1'b0;
          nent_nxt.next  = cur_r.next;
          nent_nxt.prev  = LW'(c_r);
          wd.size        = A'(need_x);
          wd.next        = LW'(free_idx);
          res_nxt        = '{ffha_pkg::ST_OK, cur_off[FW-1:0], FW'(need_x)};
          state_nxt      = ffha_pkg::S_SPLIT_WN;
        end else begin
          res_nxt   = '{ffha_pkg::ST_OK, cur_off[FW-1:0], FW'(cur_size_x)};
          state_nxt = ffha_pkg::S_SPLIT_END;
        end
      end

      ffha_pkg::S_SPLIT_WN: begin
        we = 1'b1;
        wa = ns_r;
        wd = nent_r;
        ra = nent_r.next[IW-1:0];
        state_nxt = (nent_r.next != NONE) ? ffha_pkg::S_SPLIT_NX : ffha_pkg::S_SPLIT_END;
      end

      // successor of the new tail: merge it on shrink, else relink it
      ffha_pkg::S_SPLIT_NX: begin
        if (shrink_r && !e.used) begin
          c_nxt     = ns_r;
          cur_nxt   = nent_r;
          xs_nxt    = nent_r.next[IW-1:0];
          xent_nxt  = e;
          ret_nxt   = ffha_pkg::S_FIN_W;
          state_nxt = ffha_pkg::S_MERGE;
        end else begin
          we        = 1'b1;
          wa        = nent_r.next[IW-1:0];
          wd        = e;
          wd.prev   = LW'(ns_r);
          state_nxt = ffha_pkg::S_SPLIT_END;
        end
      end

      ffha_pkg::S_SPLIT_END: begin
        ra        = os_r;
        state_nxt = grow_r ? ffha_pkg::S_GROW_OLD : ffha_pkg::S_OUT;
      end

      ffha_pkg::S_GROW_OLD: begin
        c_nxt        = os_r;
        cur_nxt      = e;
        cur_nxt.used = 1'b0;
        grow_nxt     = 1'b0;
        state_nxt    = ffha_pkg::S_REL;
      end

      ffha_pkg::S_REL: begin
        ra        = cur_r.prev[IW-1:0];
        state_nxt = (cur_r.prev != NONE) ? ffha_pkg::S_REL_PCHK : ffha_pkg::S_REL_NEXT;
      end

      ffha_pkg::S_REL_PCHK: begin
        if (!e.used) begin
          xs_nxt    = c_r;
          xent_nxt  = cur_r;
          c_nxt     = cur_r.prev[IW-1:0];
          cur_nxt   = e;
          ret_nxt   = ffha_pkg::S_REL_NEXT;
          state_nxt = ffha_pkg::S_MERGE;
        end else begin
          state_nxt = ffha_pkg::S_REL_NEXT;
        end
      end

      ffha_pkg::S_REL_NEXT: begin
        ra        = cur_r.next[IW-1:0];
        state_nxt = (cur_r.next != NONE) ? ffha_pkg::S_REL_NCHK : ffha_pkg::S_FIN_W;
      end

      ffha_pkg::S_REL_NCHK: begin
        if (!e.used) begin
          xs_nxt    = cur_r.next[IW-1:0];
          xent_nxt  = e;
          ret_nxt   = ffha_pkg::S_FIN_W;
          state_nxt = ffha_pkg::S_MERGE;
        end else begin
          state_nxt = ffha_pkg::S_FIN_W;
        end
      end

      // working segment absorbs xent; its successor gets relinked in PFIX
      ffha_pkg::S_MERGE: begin
        cur_nxt.size = A'(cur_size_x + hdr_x + CW'(xent_r.size));
        cur_nxt.next = xent_r.next;
        clr_en       = 1'b1;
        ra           = xent_r.next[IW-1:0];
        state_nxt    = (xent_r.next != NONE) ? ffha_pkg::S_PFIX : ret_r;
      end

      ffha_pkg::S_PFIX: begin
        we        = 1'b1;
        wa        = xent_r.next[IW-1:0];
        wd        = e;
        wd.prev   = LW'(c_r);
        state_nxt = ret_r;
      end

      ffha_pkg::S_FIN_W: begin
        we        = 1'b1;
        state_nxt = ffha_pkg::S_OUT;
      end

      ffha_pkg::S_OUT: begin
        if (rsp_ready) state_nxt = ffha_pkg::S_IDLE;
      end

      default: state_nxt = ffha_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/first_fit_heap_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit segment allocator with coalescing over a RAM-held segment list.
// ----------------------------------------------------------------------------
//  port     | dir | carries
//  in_req   | in  | req_type, req_bytes, handle
//  out_rsp  | out | status, data_offset, granted_bytes
//  cfg_wr   | in  | index, data (heap_bytes, header_bytes)
//
// Alloc and lookups walk the list one table read per cycle; the sequencer
// takes no new item from acceptance until its result has moved on, and a
// growing resize walks the list twice. Reinit rewrites slot zero.
// After reset slot zero is rewritten; no item or config write is taken then.
// A result waits in the output register; the next item is accepted meanwhile.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top #(
  parameter int MAX_SEGMENTS   = 64,
  parameter int HEAP_ADDR_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  ffha_req_if.sink    in_req,
  ffha_rsp_if.source  out_rsp,
  ffha_cfg_if.sink    cfg_wr
);

  logic [ffha_pkg::FIELD_W-1:0] heap_bytes_r, heap_bytes_nxt;
  logic [ffha_pkg::HREG_W-1:0]  header_bytes_r, header_bytes_nxt;
  logic                         out_valid_r, out_valid_nxt;
  ffha_pkg::rsp_t               out_r, out_nxt;
  ffha_pkg::rsp_t               rsp;
  ffha_pkg::req_t               req;
  logic                         rsp_valid, rsp_ready, cfg_ok;

  assign req = '{in_req.req_type, in_req.req_bytes, in_req.handle};

  ffha_seq #(
    .MAX_SEGMENTS   (MAX_SEGMENTS),
    .HEAP_ADDR_BITS (HEAP_ADDR_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (in_req.valid),
    .req_ready    (in_req.ready),
    .req          (req),
    .heap_bytes   (heap_bytes_r),
    .header_bytes (header_bytes_r),
    .cfg_ok       (cfg_ok),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp          (rsp)
  );

  assign cfg_wr.ready = cfg_ok;
  assign rsp_ready    = !out_valid_r || out_rsp.ready;

  always_comb begin
    heap_bytes_nxt   = heap_bytes_r;
    header_bytes_nxt = header_bytes_r;
    if (cfg_wr.valid && cfg_ok) begin
      unique case (cfg_wr.index)
        ffha_pkg::CFG_HEAP: heap_bytes_nxt   = cfg_wr.data;
        ffha_pkg::CFG_HDR:  header_bytes_nxt = cfg_wr.data[ffha_pkg::HREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (rsp_valid && rsp_ready) begin
      out_valid_nxt = 1'b1;
      out_nxt       = rsp;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_bytes_r   <= ffha_pkg::HEAP_RESET;
      header_bytes_r <= ffha_pkg::HDR_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      heap_bytes_r   <= heap_bytes_nxt;
      header_bytes_r <= header_bytes_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_r.status;
  assign out_rsp.data_offset   = out_r.data_offset;
  assign out_rsp.granted_bytes = out_r.granted_bytes;

endmodule

// ===== rtl/ffha_chk.sv =====
// ----------------------------------------------------------------------------
// ffha_chk
// Port-level checks of the heap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_top_macros.svh"

module ffha_chk (
  input logic        clk,
  input logic        rst_n,
  ffha_req_if.sink   in_req,
  ffha_rsp_if.source out_rsp
);

  `FFHA_ASSERT_NEXT(a_out_hold, out_rsp.valid && !out_rsp.ready,
    out_rsp.valid && $stable(out_rsp.status) && $stable(out_rsp.data_offset)
    && $stable(out_rsp.granted_bytes))
  `FFHA_ASSERT(a_status_code, out_rsp.valid,
    out_rsp.status == ffha_pkg::ST_OK || out_rsp.status == ffha_pkg::ST_NO_SPACE
    || out_rsp.status == ffha_pkg::ST_UNKNOWN)
  `FFHA_ASSERT(a_unknown_zero, out_rsp.valid && out_rsp.status == ffha_pkg::ST_UNKNOWN,
    out_rsp.data_offset == '0 && out_rsp.granted_bytes == '0)
  `FFHA_ASSERT_NEXT(a_busy_after_accept, in_req.valid && in_req.ready, !in_req.ready)

endmodule

bind first_fit_heap_allocator_top ffha_chk u_ffha_chk (
  .clk     (clk),
  .rst_n   (rst_n),
  .in_req  (in_req),
  .out_rsp (out_rsp)
);

// ===== bench/ffha_checker.sv =====
// ----------------------------------------------------------------------------
// ffha_checker
// Watches the request, response and config channels of the heap allocator,
// keeps its own copy of the segment table, predicts each response and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module ffha_checker
  import ffha_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  ffha_req_if.mon      req,
  ffha_rsp_if.mon      rsp,
  ffha_cfg_if          cfg,
  output int           fail_count,
  output int           pending
);

  localparam int NSEG   = 64;
  localparam int NO_SEG = NSEG;
  localparam longint unsigned AMASK = 64'hFFFFF;

  longint unsigned heap_reg, hdr_reg, hdr_act;
  longint unsigned seg_start [NSEG];
  longint unsigned seg_size  [NSEG];
  bit              seg_used  [NSEG];
  int              seg_next  [NSEG];
  int              seg_prev  [NSEG];
  bit              slot_live [NSEG];

  rsp_t expected_rsp_q [$];

  function automatic longint unsigned up16(longint unsigned v);
    return (v + 15) & ~64'd15;
  endfunction

  function automatic void rebuild_heap();
    for (int i = 0; i < NSEG; i++) begin
      seg_start[i] = 0; seg_size[i] = 0; seg_used[i] = 0;
      seg_next[i] = NO_SEG; seg_prev[i] = NO_SEG; slot_live[i] = 0;
    end
    hdr_act = up16(hdr_reg);
    if (hdr_act == 0) hdr_act = 16;
    slot_live[0] = 1;
    seg_size[0] = (heap_reg >= hdr_act) ? ((heap_reg - hdr_act) & AMASK) : 0;
  endfunction

  function automatic int take_slot();
    for (int i = 1; i < NSEG; i++)
      if (!slot_live[i]) begin
        slot_live[i] = 1;
        return i;
      end
    return NO_SEG;
  endfunction

  function automatic int cut_segment(int s, longint unsigned keep);
    longint unsigned rem;
    int n;
    rem = seg_size[s] - keep;
    if (rem < hdr_act + 16) return NO_SEG;
    n = take_slot();
    if (n == NO_SEG) return NO_SEG;
    seg_size[s]  = keep;
    seg_start[n] = (seg_start[s] + hdr_act + keep) & AMASK;
    seg_size[n]  = (rem - hdr_act) & AMASK;
    seg_used[n]  = 0;
    seg_prev[n]  = s;
    seg_next[n]  = seg_next[s];
    seg_next[s]  = n;
    if (seg_next[n] != NO_SEG) seg_prev[seg_next[n]] = n;
    return n;
  endfunction

  function automatic void join_segments(int upper, int lower);
    int nx;
    nx = seg_next[lower];
    seg_size[upper] = (seg_size[upper] + hdr_act + seg_size[lower]) & AMASK;
    seg_next[upper] = nx;
    if (nx != NO_SEG) seg_prev[nx] = upper;
    slot_live[lower] = 0; seg_used[lower] = 0;
    seg_next[lower] = NO_SEG; seg_prev[lower] = NO_SEG;
  endfunction

  function automatic int first_fit(longint unsigned need);
    int s;
    int dummy;
    s = 0;
    for (int k = 0; k < NSEG && s != NO_SEG; k++) begin
      if (!seg_used[s] && seg_size[s] >= need) begin
        seg_used[s] = 1;
        dummy = cut_segment(s, need);
        return s;
      end
      s = seg_next[s];
    end
    return NO_SEG;
  endfunction

  function automatic void free_segment(int s);
    int p, n;
    p = seg_prev[s];
    seg_used[s] = 0;
    if (p != NO_SEG && !seg_used[p]) begin
      join_segments(p, s);
      s = p;
    end
    n = seg_next[s];
    if (n != NO_SEG && !seg_used[n]) join_segments(s, n);
  endfunction

  function automatic int lookup_handle(longint unsigned h);
    int s;
    s = 0;
    for (int k = 0; k < NSEG && s != NO_SEG; k++) begin
      if (seg_used[s] && (((seg_start[s] + hdr_act) & AMASK) == h)) return s;
      s = seg_next[s];
    end
    return NO_SEG;
  endfunction

  function automatic rsp_t heap_response(req_e_t kind, longint unsigned bytes,
                                         longint unsigned h);
    longint unsigned need, off, got;
    status_e_t st;
    int s, n;
    rsp_t r;
    need = up16(bytes);
    st = ST_OK; off = 0; got = 0;
    case (kind)
      REQ_ALLOC: begin
        s = first_fit(need);
        if (s == NO_SEG) st = ST_NO_SPACE;
        else begin
          off = seg_start[s] + hdr_act;
          got = seg_size[s];
        end
      end
      REQ_FREE: begin
        s = lookup_handle(h);
        if (s == NO_SEG) st = ST_UNKNOWN;
        else begin
          free_segment(s);
          off = h;
        end
      end
      REQ_RESIZE: begin
        s = lookup_handle(h);
        if (s == NO_SEG) st = ST_UNKNOWN;
        else if (seg_size[s] > need) begin
          n = cut_segment(s, need);
          if (n != NO_SEG && seg_next[n] != NO_SEG && !seg_used[seg_next[n]])
            join_segments(n, seg_next[n]);
          off = h;
          got = seg_size[s];
        end else if (seg_size[s] < need) begin
          n = first_fit(need);
          if (n == NO_SEG) begin
            st = ST_NO_SPACE;
            off = h;
            got = seg_size[s];
          end else begin
            off = seg_start[n] + hdr_act;
            got = seg_size[n];
            free_segment(s);
          end
        end else begin
          off = h;
          got = seg_size[s];
        end
      end
      default: rebuild_heap();
    endcase
    r.status = st;
    r.data_offset = FIELD_W'(off);
    r.granted_bytes = FIELD_W'(got);
    return r;
  endfunction

  initial begin
    heap_reg = HEAP_RESET;
    hdr_reg  = HDR_RESET;
    rebuild_heap();
    fail_count = 0;
  end

  assign pending = expected_rsp_q.size();

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n) begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_HEAP) heap_reg = cfg.data;
        else hdr_reg = cfg.data[HREG_W-1:0];
      end
      if (req.valid && req.ready)
        expected_rsp_q.push_back(heap_response(req_e_t'(req.req_type),
                                               req.req_bytes, req.handle));
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected response: status %0d offset %0h bytes %0h",
                   $time, rsp.status, rsp.data_offset, rsp.granted_bytes);
          fail_count++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, rsp.status);
            fail_count++;
          end
          if (rsp.data_offset !== want.data_offset) begin
            $display("%0t: data_offset expected %0h actual %0h",
                     $time, want.data_offset, rsp.data_offset);
            fail_count++;
          end
          if (rsp.granted_bytes !== want.granted_bytes) begin
            $display("%0t: granted_bytes expected %0h actual %0h",
                     $time, want.granted_bytes, rsp.granted_bytes);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the heap allocator with directed and random alloc/free/resize/reinit
// items over several heap and header settings, with random stalls on both
// channels. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import ffha_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   no_stall = 1'b0;
  int   cycles = 0;
  int   fail_count, pending;
  logic [FIELD_W-1:0] handle_pool [$];

  ffha_req_if req_if ();
  ffha_rsp_if rsp_if ();
  ffha_cfg_if cfg_if ();

  first_fit_heap_allocator_top u_dut (
    .clk(clk), .rst_n(rst_n), .in_req(req_if), .out_rsp(rsp_if), .cfg_wr(cfg_if)
  );

  ffha_checker u_chk (
    .clk(clk), .rst_n(rst_n), .req(req_if), .rsp(rsp_if), .cfg(cfg_if),
    .fail_count(fail_count), .pending(pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk)
    rsp_if.ready <= no_stall ? 1'b1 : ($urandom_range(99) >= 36);

  // remember handed-out offsets so frees and resizes mostly hit live segments
  always @(posedge clk)
    if (rst_n && rsp_if.valid && rsp_if.ready && rsp_if.status == ST_OK &&
        rsp_if.data_offset != '0) begin
      handle_pool.push_back(rsp_if.data_offset);
      if (handle_pool.size() > 80) void'(handle_pool.pop_front());
    end

  initial begin
    req_if.valid = 1'b0; req_if.req_type = REQ_ALLOC;
    req_if.req_bytes = '0; req_if.handle = '0;
    cfg_if.valid = 1'b0; cfg_if.index = CFG_HEAP; cfg_if.data = '0;
    rsp_if.ready = 1'b0;
  end

  task automatic send_item(req_e_t kind, logic [FIELD_W-1:0] bytes,
                           logic [FIELD_W-1:0] h);
    while (!no_stall && $urandom_range(99) < 36) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= kind;
    req_if.req_bytes <= bytes;
    req_if.handle    <= h;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [FIELD_W-1:0] pick_bytes();
    int r;
    r = $urandom_range(99);
    if (r < 80) return FIELD_W'($urandom_range(600));
    if (r < 95) return FIELD_W'($urandom_range(8192));
    return FIELD_W'($urandom);
  endfunction

  function automatic logic [FIELD_W-1:0] pick_handle();
    if (handle_pool.size() != 0 && $urandom_range(99) < 80)
      return handle_pool[$urandom_range(handle_pool.size() - 1)];
    return FIELD_W'($urandom);
  endfunction

  task automatic random_items(int count, int alloc_pct);
    int r;
    for (int i = 0; i < count; i++) begin
      no_stall = (i >= count / 3 && i < count / 3 + 30);
      r = $urandom_range(99);
      if (r < alloc_pct) send_item(REQ_ALLOC, pick_bytes(), FIELD_W'($urandom));
      else if (r < alloc_pct + (98 - alloc_pct) / 2)
        send_item(REQ_FREE, FIELD_W'($urandom), pick_handle());
      else if (r < 98) send_item(REQ_RESIZE, pick_bytes(), pick_handle());
      else send_item(REQ_REINIT, FIELD_W'($urandom), FIELD_W'($urandom));
    end
    no_stall = 1'b0;
  endtask

  initial begin
    logic [FIELD_W-1:0] heaps [5] = '{20'd65536, 20'd2048, 20'hFFFFF, 20'd8, 20'd4096};
    logic [FIELD_W-1:0] hdrs  [5] = '{20'd16, 20'd64, 20'd40, 20'd16, 20'd16};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default heap, header 16
    send_item(REQ_ALLOC, 20'd0, 20'd0);
    send_item(REQ_ALLOC, 20'd1, 20'd0);
    send_item(REQ_ALLOC, 20'd17, 20'd0);
    send_item(REQ_RESIZE, 20'd32, 20'd80);       // unknown handle
    send_item(REQ_RESIZE, 20'd0, 20'd80);        // unknown handle
    send_item(REQ_RESIZE, 20'd100, 20'd48);      // unknown handle
    send_item(REQ_RESIZE, 20'hFFFFF, 20'd80);    // unknown handle
    send_item(REQ_ALLOC, 20'hFFFFF, 20'd0);      // no fit
    send_item(REQ_FREE, 20'd0, 20'd16);
    send_item(REQ_FREE, 20'd0, 20'd16);          // now unknown
    send_item(REQ_FREE, 20'hFFFFF, 20'hFFFFF);
    send_item(REQ_RESIZE, 20'd64, 20'h12345);    // unknown handle
    send_item(REQ_ALLOC, 20'd65520, 20'd0);      // larger than the free tail: no fit
    send_item(REQ_REINIT, 20'd0, 20'd0);
    // fill the segment table so splits get skipped
    for (int i = 0; i < 70; i++) send_item(REQ_ALLOC, 20'd16, 20'd0);
    send_item(REQ_RESIZE, 20'd0, 20'd48);
    send_item(REQ_ALLOC, 20'd0, 20'd0);

    for (int p = 0; p < 5; p++) begin
      wait_idle();
      write_reg(CFG_HEAP, heaps[p]);
      write_reg(CFG_HDR, hdrs[p]);
      send_item(REQ_REINIT, 20'd0, 20'd0);
      handle_pool.delete();
      random_items(130, (p == 0) ? 60 : 45);
    end

    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== first_fit_heap_allocator_top.f =====
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_if.sv
rtl/ffha_ram.sv
rtl/ffha_slots.sv
rtl/ffha_seq.sv
rtl/first_fit_heap_allocator_top.sv
rtl/ffha_chk.sv
bench/ffha_checker.sv
bench/testbench.sv
